[rtl/hbs_pkg.sv]
package hbs_pkg;

	// Fixed-point layout of the lattice coordinate.
	localparam int FRAC_BITS   = 16;
	localparam int MAX_SIDE    = 256;
	localparam int SIDE_W      = $clog2(MAX_SIDE);
	localparam int COORD_W     = SIDE_W + FRAC_BITS;
	localparam int PROD_SHIFT  = 32 - FRAC_BITS;
	localparam int GRID_W      = 64 - PROD_SHIFT;
	localparam int LERP_W      = 33 + FRAC_BITS + 1;

	// Height store and written-cell tracking.
	localparam int ADDR_W      = 16;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int CELLS_W     = 18;
	localparam int COUNT_W     = 17;
	localparam int EPOCH_W     = 16;

	// Side register width and configuration port.
	localparam int DIM_W       = 9;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SPACING = 3'd4;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]        operation;
		logic [15:0]       cell_index;
		logic signed [31:0] write_height;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sampled_height;
		logic              lattice_ok;
	} out_item_t;

endpackage

[rtl/heightfield_bilinear_sampler.sv]
// Heightfield sampler: a row-major lattice of Q24.8 heights is loaded with write beats and
// emptied with clear beats; a query beat returns the bilinear blend of the four lattice
// heights around the point, or zero with lattice_ok low while the lattice is not valid or not
// fully loaded. The block takes one beat per cycle while the pipeline is not halted; the
// ten-stage pipeline (capture, offset, coordinate multiply, clamp, address multiply, store
// read, two steps for each lerp) advances as a whole and halts while a finished result waits
// on rsp_ready or a tag sweep runs. Each of the four neighbors comes from one read port of
// two mirrored copies of the height store. Distinct cells are counted with a per-cell epoch
// tag; the tag store is swept after reset and again after every 65535th clear beat, and no
// beat is accepted during a sweep (configuration writes are still taken).
module heightfield_bilinear_sampler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  hbs_pkg::in_item_t             req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output hbs_pkg::out_item_t            rsp,
	input  logic                          cfg_write,
	input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hbs_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Configuration.
	logic [hbs_pkg::DIM_W-1:0] cols_q, rows_q;
	logic signed [31:0]        origin_x_q, origin_y_q;
	logic [31:0]               inv_q;

	// Store tracking.
	logic [hbs_pkg::EPOCH_W-1:0] tag_mem [hbs_pkg::STORE_DEPTH];
	logic [31:0]                 hgt_a [hbs_pkg::STORE_DEPTH];
	logic [31:0]                 hgt_b [hbs_pkg::STORE_DEPTH];
	logic [hbs_pkg::EPOCH_W-1:0] epoch_q;
	logic [hbs_pkg::COUNT_W-1:0] loaded_q;
	logic                        clearing_q;
	logic [hbs_pkg::ADDR_W-1:0]  clr_addr_q;

	logic advance;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// Stage 1: accepted beat.
	logic [1:0]                  op_s1;
	logic [hbs_pkg::ADDR_W-1:0]  idx_s1;
	logic signed [31:0]          wh_s1, px_s1, py_s1;
	logic [hbs_pkg::EPOCH_W-1:0] tag_s1;

	// Stage 2: offsets from the origin.
	logic                        qry_s2, ok_s2, wr_s2;
	logic [hbs_pkg::ADDR_W-1:0]  idx_s2;
	logic signed [31:0]          wh_s2;
	logic [31:0]                 dx_s2, dy_s2;

	// Stage 3: scaled coordinates.
	logic                        qry_s3, ok_s3, wr_s3;
	logic [hbs_pkg::ADDR_W-1:0]  idx_s3;
	logic signed [31:0]          wh_s3;
	logic [63:0]                 gxp_s3, gyp_s3;

	// Stage 4: clamped coordinates.
	logic                        qry_s4, ok_s4, wr_s4;
	logic [hbs_pkg::ADDR_W-1:0]  idx_s4;
	logic signed [31:0]          wh_s4;
	logic [hbs_pkg::COORD_W-1:0] gx_s4, gy_s4;

	// Stage 5: base address.
	logic                        qry_s5, ok_s5, wr_s5;
	logic [hbs_pkg::ADDR_W-1:0]  idx_s5, i00_s5;
	logic signed [31:0]          wh_s5;
	logic [hbs_pkg::FRAC_BITS-1:0] tx_s5, ty_s5;

	// Stages 6 to 9: interpolation.
	logic                          ok_s6, ok_s7, ok_s8, ok_s9;
	logic signed [31:0]            h00_s6, h10_s6, h01_s6, h11_s6;
	logic [hbs_pkg::FRAC_BITS-1:0] tx_s6, ty_s6, ty_s7, ty_s8;
	logic signed [31:0]            h00_s7, h01_s7;
	logic signed [hbs_pkg::LERP_W-1:0] plo_s7, pup_s7;
	logic signed [31:0]            lo_s8, up_s8, lo_s9;
	logic signed [hbs_pkg::LERP_W-1:0] py_s9;

	// Combinational terms.
	logic [hbs_pkg::CELLS_W-1:0] cells;
	logic                        lattice_valid;
	logic                        wr_ok_s1, written_s1, tag_we;
	logic signed [32:0]          diff_x, diff_y;
	logic [hbs_pkg::COORD_W-1:0] hi_x, hi_y;
	logic [hbs_pkg::GRID_W-1:0]  g_x, g_y;
	logic [hbs_pkg::SIDE_W-1:0]  x0, y0;
	logic [hbs_pkg::ADDR_W-1:0]  i10, i01, i11;
	logic signed [32:0]          d_lo, d_up, d_y;
	logic signed [31:0]          blend;

	assign advance   = !clearing_q && (!rsp_valid || rsp_ready);
	assign req_ready = advance;

	assign cells = hbs_pkg::CELLS_W'(cols_q) * hbs_pkg::CELLS_W'(rows_q);
	assign lattice_valid = (cols_q >= hbs_pkg::DIM_W'(2)) && (rows_q >= hbs_pkg::DIM_W'(2)) &&
		(cols_q <= hbs_pkg::DIM_W'(hbs_pkg::MAX_SIDE)) &&
		(rows_q <= hbs_pkg::DIM_W'(hbs_pkg::MAX_SIDE)) &&
		(hbs_pkg::CELLS_W'(loaded_q) == cells);

	assign wr_ok_s1 = (op_s1 == hbs_pkg::OP_WRITE) && (hbs_pkg::CELLS_W'(idx_s1) < cells);
	// The tag read for this beat misses a write made by the beat just ahead of it.
	assign written_s1 = (tag_s1 == epoch_q) || (v_s2 && wr_s2 && (idx_s2 == idx_s1));
	assign tag_we = v_s1 && wr_ok_s1;

	assign diff_x = {px_s1[31], px_s1} - {origin_x_q[31], origin_x_q};
	assign diff_y = {py_s1[31], py_s1} - {origin_y_q[31], origin_y_q};

	assign hi_x = hbs_pkg::COORD_W'({cols_q - hbs_pkg::DIM_W'(1), {hbs_pkg::FRAC_BITS{1'b0}}})
		- hbs_pkg::COORD_W'(1);
	assign hi_y = hbs_pkg::COORD_W'({rows_q - hbs_pkg::DIM_W'(1), {hbs_pkg::FRAC_BITS{1'b0}}})
		- hbs_pkg::COORD_W'(1);
	assign g_x = gxp_s3[63:hbs_pkg::PROD_SHIFT];
	assign g_y = gyp_s3[63:hbs_pkg::PROD_SHIFT];

	assign x0 = gx_s4[hbs_pkg::COORD_W-1:hbs_pkg::FRAC_BITS];
	assign y0 = gy_s4[hbs_pkg::COORD_W-1:hbs_pkg::FRAC_BITS];

	assign i10 = i00_s5 + hbs_pkg::ADDR_W'(1);
	assign i01 = i00_s5 + hbs_pkg::ADDR_W'(cols_q);
	assign i11 = i01 + hbs_pkg::ADDR_W'(1);

	assign d_lo = {h10_s6[31], h10_s6} - {h00_s6[31], h00_s6};
	assign d_up = {h11_s6[31], h11_s6} - {h01_s6[31], h01_s6};
	assign d_y  = {up_s8[31], up_s8} - {lo_s8[31], lo_s8};
	assign blend = lo_s9 + 32'(py_s9 >>> hbs_pkg::FRAC_BITS);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q     <= '0;
			rows_q     <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			inv_q      <= '0;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			epoch_q    <= hbs_pkg::EPOCH_W'(1);
			loaded_q   <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					hbs_pkg::CFG_GRID_COLUMNS:    cols_q     <= cfg_data[hbs_pkg::DIM_W-1:0];
					hbs_pkg::CFG_GRID_ROWS:       rows_q     <= cfg_data[hbs_pkg::DIM_W-1:0];
					hbs_pkg::CFG_ORIGIN_X:        origin_x_q <= cfg_data;
					hbs_pkg::CFG_ORIGIN_Y:        origin_y_q <= cfg_data;
					hbs_pkg::CFG_INVERSE_SPACING: inv_q      <= cfg_data;
					default: ;
				endcase
			end

			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + hbs_pkg::ADDR_W'(1);
				if (clr_addr_q == '1) begin
					clearing_q <= 1'b0;
				end
			end

			if (advance) begin
				v_s1 <= req_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5 && qry_s5;
				v_s7 <= v_s6;
				v_s8 <= v_s7;
				v_s9 <= v_s8;
				rsp_valid <= v_s9;
				if (v_s1 && (op_s1 == hbs_pkg::OP_CLEAR)) begin
					loaded_q <= '0;
					// Epoch tags would repeat after the last value, so the tag store is swept.
					if (epoch_q == '1) begin
						epoch_q    <= hbs_pkg::EPOCH_W'(1);
						clearing_q <= 1'b1;
					end else begin
						epoch_q <= epoch_q + hbs_pkg::EPOCH_W'(1);
					end
				end else if (tag_we && !written_s1) begin
					loaded_q <= loaded_q + hbs_pkg::COUNT_W'(1);
				end
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// Epoch tag store: one write port shared with the sweep, one read port.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			tag_mem[clr_addr_q] <= '0;
		end else if (advance && tag_we) begin
			tag_mem[idx_s1] <= epoch_q;
		end
	end

	// Two mirrored height stores, each with one write and two reads.
	always_ff @(posedge clk) begin
		if (advance && v_s5 && wr_s5) begin
			hgt_a[idx_s5] <= wh_s5;
			hgt_b[idx_s5] <= wh_s5;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			tag_s1 <= '0;
		end else if (advance) begin
			tag_s1 <= tag_mem[req.cell_index];
		end

		if (advance) begin
			op_s1  <= req.operation;
			idx_s1 <= req.cell_index;
			wh_s1  <= req.write_height;
			px_s1  <= req.point_x;
			py_s1  <= req.point_y;

			qry_s2 <= (op_s1 == hbs_pkg::OP_QUERY);
			ok_s2  <= lattice_valid;
			wr_s2  <= wr_ok_s1;
			idx_s2 <= idx_s1;
			wh_s2  <= wh_s1;
			// A point on or below the origin maps to coordinate zero.
			dx_s2  <= (!diff_x[32] && (diff_x != '0)) ? diff_x[31:0] : '0;
			dy_s2  <= (!diff_y[32] && (diff_y != '0)) ? diff_y[31:0] : '0;

			qry_s3 <= qry_s2;
			ok_s3  <= ok_s2;
			wr_s3  <= wr_s2;
			idx_s3 <= idx_s2;
			wh_s3  <= wh_s2;
			gxp_s3 <= {32'd0, dx_s2} * {32'd0, inv_q};
			gyp_s3 <= {32'd0, dy_s2} * {32'd0, inv_q};

			qry_s4 <= qry_s3;
			ok_s4  <= ok_s3;
			wr_s4  <= wr_s3;
			idx_s4 <= idx_s3;
			wh_s4  <= wh_s3;
			gx_s4  <= (g_x > hbs_pkg::GRID_W'(hi_x)) ? hi_x : g_x[hbs_pkg::COORD_W-1:0];
			gy_s4  <= (g_y > hbs_pkg::GRID_W'(hi_y)) ? hi_y : g_y[hbs_pkg::COORD_W-1:0];

			qry_s5 <= qry_s4;
			ok_s5  <= ok_s4;
			wr_s5  <= wr_s4;
			idx_s5 <= idx_s4;
			wh_s5  <= wh_s4;
			i00_s5 <= hbs_pkg::ADDR_W'(hbs_pkg::CELLS_W'(y0) * hbs_pkg::CELLS_W'(cols_q)
				+ hbs_pkg::CELLS_W'(x0));
			tx_s5  <= gx_s4[hbs_pkg::FRAC_BITS-1:0];
			ty_s5  <= gy_s4[hbs_pkg::FRAC_BITS-1:0];

			ok_s6  <= ok_s5;
			h00_s6 <= hgt_a[i00_s5];
			h10_s6 <= hgt_a[i10];
			h01_s6 <= hgt_b[i01];
			h11_s6 <= hgt_b[i11];
			tx_s6  <= tx_s5;
			ty_s6  <= ty_s5;

			ok_s7  <= ok_s6;
			h00_s7 <= h00_s6;
			h01_s7 <= h01_s6;
			plo_s7 <= hbs_pkg::LERP_W'(d_lo) * hbs_pkg::LERP_W'($signed({1'b0, tx_s6}));
			pup_s7 <= hbs_pkg::LERP_W'(d_up) * hbs_pkg::LERP_W'($signed({1'b0, tx_s6}));
			ty_s7  <= ty_s6;

			// Arithmetic shift of the product rounds toward minus infinity.
			ok_s8 <= ok_s7;
			lo_s8 <= h00_s7 + 32'(plo_s7 >>> hbs_pkg::FRAC_BITS);
			up_s8 <= h01_s7 + 32'(pup_s7 >>> hbs_pkg::FRAC_BITS);
			ty_s8 <= ty_s7;

			ok_s9 <= ok_s8;
			lo_s9 <= lo_s8;
			py_s9 <= hbs_pkg::LERP_W'(d_y) * hbs_pkg::LERP_W'($signed({1'b0, ty_s8}));

			rsp.sampled_height <= ok_s9 ? blend : '0;
			rsp.lattice_ok     <= ok_s9;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req_ready)
		else $error("beat accepted during tag sweep");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= hbs_pkg::COUNT_W'(hbs_pkg::STORE_DEPTH))
		else $error("loaded count beyond store depth");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.lattice_ok) |-> (rsp.sampled_height == '0))
		else $error("invalid lattice result is not zero");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s1 && (op_s1 == hbs_pkg::OP_CLEAR)) |=> (loaded_q == '0))
		else $error("clear beat did not empty the loaded count");
`endif

endmodule

[bench/heightfield_bilinear_sampler_tb.sv]
`timescale 1ns / 100ps

module heightfield_bilinear_sampler_tb;
	import hbs_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD_CYCLES = 400;
	// The tag sweep after reset alone runs with no beat accepted.
	localparam int WATCHDOG_LIMIT = 262144;
	localparam int LOAD_ALL = 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	in_item_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	out_item_t rsp;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	heightfield_bilinear_sampler uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the configuration and the lattice store.
	logic [8:0] cfg_columns = '0;
	logic [8:0] cfg_rows = '0;
	logic [31:0] cfg_origin_x = '0;
	logic [31:0] cfg_origin_y = '0;
	logic [31:0] cfg_inv_spacing = '0;
	logic signed [31:0] lattice_heights [0:STORE_DEPTH-1];
	int unsigned cell_epoch [0:STORE_DEPTH-1];
	int unsigned clear_epoch = 1;
	logic [COUNT_W-1:0] cells_loaded = '0;

	in_item_t pending_beats[$];
	out_item_t expected_samples[$];
	out_item_t want_sample;
	int unsigned beats_queued = 0;
	int unsigned beats_accepted = 0;
	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 27;
	int unsigned recv_idle_pct = 49;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	bit long_hold_armed = 1'b0;
	bit long_hold_done = 1'b0;

	always #5 clk = ~clk;

	function automatic bit [63:0] grid_coord(logic [31:0] point, logic [31:0] origin,
			bit [63:0] hi);
		longint diff;
		bit [63:0] diff_u;
		bit [63:0] g;
		diff = longint'($signed(point)) - longint'($signed(origin));
		if (diff <= 0)
			return 64'd0;
		diff_u = diff;
		g = (diff_u * {32'd0, cfg_inv_spacing}) >> PROD_SHIFT;
		return (g > hi) ? hi : g;
	endfunction

	// Arithmetic shift floors the scaled difference toward minus infinity.
	function automatic longint blend(longint a, longint b, longint t);
		return a + (((b - a) * t) >>> FRAC_BITS);
	endfunction

	function automatic out_item_t sample_lattice(logic [31:0] px, logic [31:0] py);
		out_item_t r;
		longint cells;
		bit [63:0] hx, hy, gx, gy, fmask;
		int unsigned x0, y0, i00, i10, i01, i11;
		longint tx, ty, lo, up;
		r = '0;
		cells = longint'(cfg_columns) * longint'(cfg_rows);
		if (cfg_columns < 2 || cfg_rows < 2 || cfg_columns > MAX_SIDE || cfg_rows > MAX_SIDE ||
				cells > STORE_DEPTH || longint'(cells_loaded) != cells)
			return r;
		hx = ((64'(cfg_columns) - 64'd1) << FRAC_BITS) - 64'd1;
		hy = ((64'(cfg_rows) - 64'd1) << FRAC_BITS) - 64'd1;
		gx = grid_coord(px, cfg_origin_x, hx);
		gy = grid_coord(py, cfg_origin_y, hy);
		fmask = (64'd1 << FRAC_BITS) - 64'd1;
		x0 = int'(gx >> FRAC_BITS);
		y0 = int'(gy >> FRAC_BITS);
		tx = longint'(gx & fmask);
		ty = longint'(gy & fmask);
		i00 = (y0 * cfg_columns + x0) % STORE_DEPTH;
		i10 = (i00 + 1) % STORE_DEPTH;
		i01 = (i00 + cfg_columns) % STORE_DEPTH;
		i11 = (i01 + 1) % STORE_DEPTH;
		lo = blend(longint'(lattice_heights[i00]), longint'(lattice_heights[i10]), tx);
		up = blend(longint'(lattice_heights[i01]), longint'(lattice_heights[i11]), tx);
		r.sampled_height = 32'(blend(lo, up, ty));
		r.lattice_ok = 1'b1;
		return r;
	endfunction

	function automatic void track_beat(in_item_t beat);
		longint cells;
		cells = longint'(cfg_columns) * longint'(cfg_rows);
		case (beat.operation)
			OP_WRITE: begin
				if (longint'(beat.cell_index) < cells) begin
					lattice_heights[beat.cell_index] = beat.write_height;
					if (cell_epoch[beat.cell_index] != clear_epoch) begin
						cell_epoch[beat.cell_index] = clear_epoch;
						cells_loaded = cells_loaded + 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				clear_epoch++;
				cells_loaded = '0;
			end
			OP_QUERY: begin
				expected_samples.push_back(sample_lattice(beat.point_x, beat.point_y));
			end
			default: begin
			end
		endcase
	endfunction

	// Sender: a new beat is loaded only when the current one has gone.
	always @(posedge clk) begin
		if (!req_valid || req_ready) begin
			if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req <= pending_beats.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (long_hold_armed && !long_hold_done) begin
			hold_left <= LONG_HOLD_CYCLES;
			long_hold_done <= 1'b1;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (req_valid && req_ready) begin
			track_beat(req);
			beats_accepted++;
		end
		if (rsp_valid && rsp_ready) begin
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: height %0d ok %0b", rsp.sampled_height,
						rsp.lattice_ok);
			end else begin
				want_sample = expected_samples.pop_front();
				if (rsp.sampled_height !== want_sample.sampled_height ||
						rsp.lattice_ok !== want_sample.lattice_ok) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: height exp %0d got %0d, ok exp %0b got %0b",
							want_sample.sampled_height, rsp.sampled_height,
							want_sample.lattice_ok, rsp.lattice_ok);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_beat(in_item_t beat);
		pending_beats.push_back(beat);
		beats_queued++;
	endtask

	function automatic in_item_t make_beat(logic [1:0] op);
		in_item_t beat;
		beat.operation = op;
		beat.cell_index = 16'($urandom);
		beat.write_height = $urandom;
		beat.point_x = $urandom;
		beat.point_y = $urandom;
		return beat;
	endfunction

	task automatic queue_op(logic [1:0] op);
		queue_beat(make_beat(op));
	endtask

	task automatic queue_write(logic [15:0] idx, logic [31:0] h);
		in_item_t beat;
		beat = make_beat(OP_WRITE);
		beat.cell_index = idx;
		beat.write_height = h;
		queue_beat(beat);
	endtask

	task automatic queue_query(logic [31:0] px, logic [31:0] py);
		in_item_t beat;
		beat = make_beat(OP_QUERY);
		beat.point_x = px;
		beat.point_y = py;
		queue_beat(beat);
	endtask

	function automatic logic [31:0] random_height();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Map distance covered by one side of the lattice, in Q24.8 units.
	function automatic longint span_for(int unsigned side, logic [31:0] inv);
		longint s;
		int unsigned side_c;
		side_c = (side < 2) ? 2 : (side > MAX_SIDE) ? MAX_SIDE : side;
		if (inv == 0)
			return longint'(1) << 20;
		s = (longint'(side_c) << 32) / longint'({32'd0, inv});
		if (s > (longint'(1) << 30))
			s = longint'(1) << 30;
		return (s < 1) ? 1 : s;
	endfunction

	function automatic logic [31:0] near_point(logic [31:0] origin, longint span);
		longint offset;
		offset = longint'($urandom_range(0, int'(span + span / 8))) - span / 16;
		return 32'(longint'($signed(origin)) + offset);
	endfunction

	task automatic queue_noise(longint cells);
		case ($urandom_range(2))
			0: queue_op(OP_RESERVED);
			1: begin
				if (cells < STORE_DEPTH)
					queue_write(16'($urandom_range(int'(cells), STORE_DEPTH - 1)),
						random_height());
				else
					queue_op(OP_RESERVED);
			end
			default: queue_query($urandom, $urandom);
		endcase
	endtask

	task automatic load_cells(longint cells, int unsigned limit);
		int unsigned order[$];
		int unsigned pick, swap_tmp, n;
		if (cells > STORE_DEPTH) begin
			repeat (limit) queue_write(16'($urandom), random_height());
			return;
		end
		for (int unsigned i = 0; i < cells; i++)
			order.push_back(i);
		for (int i = int'(cells) - 1; i > 0; i--) begin
			pick = $urandom_range(0, i);
			swap_tmp = order[i];
			order[i] = order[pick];
			order[pick] = swap_tmp;
		end
		n = (limit < cells) ? limit : int'(cells);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(99) < 8)
				queue_noise(cells);
			queue_write(16'(order[i]), random_height());
		end
	endtask

	task automatic wait_drained();
		while (beats_accepted != beats_queued || expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_GRID_COLUMNS: cfg_columns = value[8:0];
			CFG_GRID_ROWS: cfg_rows = value[8:0];
			CFG_ORIGIN_X: cfg_origin_x = value;
			CFG_ORIGIN_Y: cfg_origin_y = value;
			CFG_INVERSE_SPACING: cfg_inv_spacing = value;
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Every setting starts from an empty lattice so no stale cell is ever read.
	task automatic configure(int unsigned cols, int unsigned rows, logic [31:0] ox,
			logic [31:0] oy, logic [31:0] inv);
		wait_drained();
		write_reg(CFG_GRID_COLUMNS, 32'(cols));
		write_reg(CFG_GRID_ROWS, 32'(rows));
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_INVERSE_SPACING, inv);
		queue_op(OP_CLEAR);
	endtask

	task automatic run_phase(int unsigned cols, int unsigned rows, logic [31:0] ox,
			logic [31:0] oy, logic [31:0] inv, int unsigned load_limit, int unsigned n_queries);
		longint cells, span_x, span_y;
		int unsigned roll, top;
		cells = longint'(cols) * longint'(rows);
		top = (cells > STORE_DEPTH) ? STORE_DEPTH - 1 : int'(cells) - 1;
		span_x = span_for(cols, inv);
		span_y = span_for(rows, inv);
		configure(cols, rows, ox, oy, inv);
		load_cells(cells, load_limit);
		for (int unsigned q = 0; q < n_queries; q++) begin
			if (q == n_queries / 2 && cells <= 64 && load_limit >= cells) begin
				// A query between the clear and the reload must see an empty lattice.
				queue_op(OP_CLEAR);
				queue_query(near_point(ox, span_x), near_point(oy, span_y));
				load_cells(cells, load_limit);
			end
			roll = $urandom_range(99);
			if (roll < 6 && cells != 0)
				queue_write(16'($urandom_range(0, top)), random_height());
			else if (roll < 9)
				queue_noise(cells);
			else if (roll < 18)
				queue_query($urandom, $urandom);
			else
				queue_query(near_point(ox, span_x), near_point(oy, span_y));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats on a 3 x 2 lattice with one map unit per lattice step.
		queue_query(32'h0, 32'h0);
		configure(3, 2, 32'h0, 32'h0, 32'h0100_0000);
		queue_query(32'h100, 32'h80);
		queue_write(16'd0, 32'h7FFF_FFFF);
		queue_write(16'd1, 32'h8000_0000);
		queue_write(16'd2, 32'h0);
		queue_query(32'h100, 32'h80);
		queue_write(16'd3, 32'hFFFF_FFFF);
		queue_write(16'd4, 32'h1);
		queue_write(16'd6, 32'h55);
		queue_write(16'hFFFF, 32'h66);
		queue_op(OP_RESERVED);
		queue_query(32'h100, 32'h80);
		queue_write(16'd5, 32'h1234_5678);
		queue_write(16'd0, 32'h4000_0000);
		queue_query(32'h0, 32'h0);
		queue_query(32'hFFFF_FF00, 32'hFFFF_FFFF);
		queue_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_query(32'h8000_0000, 32'h7FFF_FFFF);
		queue_query(32'h180, 32'h40);
		queue_query(32'h1FF, 32'hFF);
		queue_op(OP_CLEAR);
		queue_query(32'h180, 32'h40);

		run_phase(4, 3, $urandom, $urandom, $urandom_range(32'h0010_0000, 32'h1000_0000),
			LOAD_ALL, 30);
		run_phase(2, 2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, LOAD_ALL, 25);

		send_idle_pct = 49;
		recv_idle_pct = 27;
		run_phase(256, 2, $urandom, $urandom, $urandom_range(32'h0010_0000, 32'h1000_0000),
			LOAD_ALL, 25);
		run_phase(511, 511, $urandom, $urandom, $urandom, 30, 20);
		run_phase(1, 5, $urandom, $urandom, 32'h0, LOAD_ALL, 15);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(2, 256, 32'h7FFF_FFFF, 32'h8000_0000,
			$urandom_range(32'h0010_0000, 32'h1000_0000), 30, 15);
		run_phase(257, 3, $urandom, $urandom, $urandom, 20, 10);
		run_phase(5, 4, $urandom, $urandom, $urandom_range(32'h0010_0000, 32'h1000_0000),
			LOAD_ALL, 20);
		// A finished result waits on the stalled receiver, which halts the pipeline and the input.
		long_hold_armed = 1'b1;
		run_phase(3, 7, $urandom, $urandom, $urandom_range(32'h0010_0000, 32'h1000_0000),
			LOAD_ALL, 25);

		wait_drained();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
